### hw/rtl/sha256h_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
package sha256h_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT_HI,
    ST_OUT_LO,
    ST_OUT_LATCH
  } state_t;

  // Where the sequencer resumes once a compression has been folded in.
  typedef enum logic [1:0] {
    AFTER_IDLE,
    AFTER_PAD,
    AFTER_ZERO,
    AFTER_OUT
  } cont_t;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [1:0] LANE_LAST      = 2'd3;
  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [3:0] LAST_ZERO_WORD = 4'd13;
  localparam logic [3:0] LEN_HI_WORD    = 4'd14;
  localparam logic [3:0] LEN_LO_WORD    = 4'd15;
  localparam logic [5:0] LOAD_LAST      = 6'd16;
  localparam logic [5:0] CV_LOAD_LAST   = 6'd8;
  localparam logic [5:0] ROUND_LAST     = 6'd63;
  localparam logic [5:0] UPDATE_LAST    = 6'd8;
  localparam logic [1:0] DIGEST_LAST    = 2'd3;
  localparam logic [63:0] BYTE_BITS     = 64'd8;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  // Drop a byte into its big-endian lane of the word being assembled.
  function automatic logic [31:0] set_lane(input logic [31:0] acc, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    case (lane)
      2'd0:    r = {b, acc[23:0]};
      2'd1:    r = {acc[31:24], b, acc[15:0]};
      2'd2:    r = {acc[31:16], b, acc[7:0]};
      default: r = {acc[31:8], b};
    endcase
    return r;
  endfunction

  // Keep the message bytes ahead of the lane, put the pad byte in it, zero the rest.
  function automatic logic [31:0] pad_word(input logic [31:0] acc, input logic [1:0] lane);
    logic [31:0] r;
    case (lane)
      2'd0:    r = {PAD_BYTE, 24'd0};
      2'd1:    r = {acc[31:24], PAD_BYTE, 16'd0};
      2'd2:    r = {acc[31:16], PAD_BYTE, 8'd0};
      default: r = {acc[31:8], PAD_BYTE};
    endcase
    return r;
  endfunction

  function automatic logic [31:0] initial_hash(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/sha256h_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for message bytes in and digest words out.
interface sha256h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source(output valid, output data_byte, output byte_present, output end_of_message,
                 input ready);
  modport sink(input valid, input data_byte, input byte_present, input end_of_message,
               output ready);
endinterface

interface sha256h_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_number;
  logic        last_word;

  modport source(output valid, output digest_word, output word_number, output last_word,
                 input ready);
  modport sink(input valid, input digest_word, input word_number, input last_word,
               output ready);
endinterface

### hw/rtl/sha256h_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module sha256h_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// Top level of the SHA-256 byte stream hasher: sequencer, round datapath and two RAMs.
//
//   channel | direction | transaction                                  | accepted when
//   in_ch   | sink      | data_byte, byte_present, end_of_message      | valid && ready
//   out_ch  | source    | digest_word, word_number, last_word          | valid && ready
//
// Sequence: a transaction that only adds a byte leaves in_ch ready, unless it is the 64th
// byte of a block, which starts a compression (loading the block and chaining RAMs, 64 rounds
// on one shared round unit, folding back into the chaining RAM). Finishing a message runs a
// pad step, zero fill, the two length words, one or two compressions, then chaining RAM
// reads for each digest word.
// Reset: synchronous; the chaining RAM reads as the initial hash through per-entry valid
// bits, so no clearing pass is needed. A stalled digest word holds in the output register
// and only the following word waits; in_ch takes a new message once word 3 is latched.
module sha256_byte_stream_hasher (
  input logic               clk,
  input logic               rst_n,
  sha256h_in_if.sink        in_ch,
  sha256h_out_if.source     out_ch
);

  sha256h_pkg::state_t state_r, state_nxt;
  sha256h_pkg::cont_t  after_r, after_nxt;

  logic [5:0]  cnt_r, cnt_nxt;       // load / round / fold-back step
  logic [3:0]  wi_r, wi_nxt;         // block word index during padding
  logic [1:0]  dw_r, dw_nxt;         // digest word index
  logic [5:0]  fill_r, fill_nxt;     // bytes held in the current block
  logic [63:0] len_r, len_nxt;       // message length in bits
  logic [31:0] acc_r, acc_nxt;       // partial word being assembled
  logic [7:0]  cv_valid_r, cv_valid_nxt;
  logic [31:0] hi_r, hi_nxt;

  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_word_r, out_word_nxt;
  logic [1:0]  out_num_r, out_num_nxt;
  logic        out_last_r, out_last_nxt;

  // RAM ports
  logic        blk_we;
  logic [3:0]  blk_waddr, blk_raddr;
  logic [31:0] blk_wdata, blk_rdata;
  logic        cv_we;
  logic [2:0]  cv_waddr, cv_raddr, cv_raddr_q_r;
  logic [31:0] cv_wdata, cv_rdata, cv_rd_eff;
  logic        cv_hit_r;

  // Round datapath
  logic [31:0] t1, t2, w_new, byte_word;
  logic [3:0]  pad_idx;

  sha256h_ram #(.WIDTH(32), .DEPTH(16)) u_blk_ram (
    .clk  (clk),
    .we   (blk_we),
    .waddr(blk_waddr),
    .wdata(blk_wdata),
    .raddr(blk_raddr),
    .rdata(blk_rdata)
  );

  sha256h_ram #(.WIDTH(32), .DEPTH(8)) u_cv_ram (
    .clk  (clk),
    .we   (cv_we),
    .waddr(cv_waddr),
    .wdata(cv_wdata),
    .raddr(cv_raddr),
    .rdata(cv_rdata)
  );

  // An entry never written since reset or since the last digest reads as the initial hash.
  assign cv_rd_eff = cv_hit_r ? cv_rdata : sha256h_pkg::initial_hash(cv_raddr_q_r);

  assign t1 = v_r[7] + sha256h_pkg::big_sigma1(v_r[4])
            + sha256h_pkg::choose(v_r[4], v_r[5], v_r[6])
            + sha256h_pkg::round_k(cnt_r) + w_r[0];
  assign t2 = sha256h_pkg::big_sigma0(v_r[0]) + sha256h_pkg::majority(v_r[0], v_r[1], v_r[2]);
  // Schedule word t+16 from the 16-word window.
  assign w_new = sha256h_pkg::small_sigma1(w_r[14]) + w_r[9]
               + sha256h_pkg::small_sigma0(w_r[1]) + w_r[0];

  assign byte_word = sha256h_pkg::set_lane(acc_r, fill_r[1:0], in_ch.data_byte);
  assign pad_idx   = fill_r[5:2];

  assign in_ch.ready        = (state_r == sha256h_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_number = out_num_r;
  assign out_ch.last_word   = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    cnt_nxt       = cnt_r;
    wi_nxt        = wi_r;
    dw_nxt        = dw_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    acc_nxt       = acc_r;
    cv_valid_nxt  = cv_valid_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    for (int i = 0; i < 8; i++) begin
      v_nxt[i] = v_r[i];
    end
    for (int i = 0; i < 16; i++) begin
      w_nxt[i] = w_r[i];
    end

    blk_we    = 1'b0;
    blk_waddr = wi_r;
    blk_wdata = 32'd0;
    blk_raddr = cnt_r[3:0];
    cv_we     = 1'b0;
    cv_waddr  = cnt_r[2:0] - 3'd1;
    cv_wdata  = cv_rd_eff + v_r[0];
    cv_raddr  = cnt_r[2:0];

    // Drop the output word once the sink takes it.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sha256h_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.byte_present) begin
            acc_nxt  = byte_word;
            len_nxt  = len_r + sha256h_pkg::BYTE_BITS;
            fill_nxt = fill_r + 6'd1;
            if (fill_r[1:0] == sha256h_pkg::LANE_LAST) begin
              blk_we    = 1'b1;
              blk_waddr = fill_r[5:2];
              blk_wdata = byte_word;
            end
          end
          if (in_ch.byte_present && fill_r == sha256h_pkg::FILL_LAST) begin
            state_nxt = sha256h_pkg::ST_LOAD;
            cnt_nxt   = 6'd0;
            after_nxt = in_ch.end_of_message ? sha256h_pkg::AFTER_PAD
                                             : sha256h_pkg::AFTER_IDLE;
          end else if (in_ch.end_of_message) begin
            state_nxt = sha256h_pkg::ST_PAD;
          end
        end
      end

      sha256h_pkg::ST_PAD: begin
        blk_we    = 1'b1;
        blk_waddr = pad_idx;
        blk_wdata = sha256h_pkg::pad_word(acc_r, fill_r[1:0]);
        wi_nxt    = pad_idx + 4'd1;
        if (pad_idx == sha256h_pkg::LAST_ZERO_WORD) begin
          state_nxt = sha256h_pkg::ST_LEN_HI;
        end else if (pad_idx == sha256h_pkg::LEN_LO_WORD) begin
          // Pad byte closes the block: compress it, then zero-fill a fresh one.
          state_nxt = sha256h_pkg::ST_LOAD;
          cnt_nxt   = 6'd0;
          after_nxt = sha256h_pkg::AFTER_ZERO;
        end else begin
          state_nxt = sha256h_pkg::ST_ZERO;
        end
      end

      sha256h_pkg::ST_ZERO: begin
        blk_we    = 1'b1;
        blk_waddr = wi_r;
        blk_wdata = 32'd0;
        if (wi_r == sha256h_pkg::LEN_LO_WORD) begin
          // No room for the length: compress this block and start another.
          state_nxt = sha256h_pkg::ST_LOAD;
          cnt_nxt   = 6'd0;
          after_nxt = sha256h_pkg::AFTER_ZERO;
          wi_nxt    = 4'd0;
        end else if (wi_r == sha256h_pkg::LAST_ZERO_WORD) begin
          state_nxt = sha256h_pkg::ST_LEN_HI;
        end else begin
          wi_nxt = wi_r + 4'd1;
        end
      end

      sha256h_pkg::ST_LEN_HI: begin
        blk_we    = 1'b1;
        blk_waddr = sha256h_pkg::LEN_HI_WORD;
        blk_wdata = len_r[63:32];
        state_nxt = sha256h_pkg::ST_LEN_LO;
      end

      sha256h_pkg::ST_LEN_LO: begin
        blk_we    = 1'b1;
        blk_waddr = sha256h_pkg::LEN_LO_WORD;
        blk_wdata = len_r[31:0];
        state_nxt = sha256h_pkg::ST_LOAD;
        cnt_nxt   = 6'd0;
        after_nxt = sha256h_pkg::AFTER_OUT;
      end

      sha256h_pkg::ST_LOAD: begin
        // Read data arrives the cycle after its address: shift it into the windows.
        if (cnt_r != 6'd0) begin
          for (int i = 0; i < 15; i++) begin
            w_nxt[i] = w_r[i + 1];
          end
          w_nxt[15] = blk_rdata;
          if (cnt_r <= sha256h_pkg::CV_LOAD_LAST) begin
            for (int i = 0; i < 7; i++) begin
              v_nxt[i] = v_r[i + 1];
            end
            v_nxt[7] = cv_rd_eff;
          end
        end
        if (cnt_r == sha256h_pkg::LOAD_LAST) begin
          state_nxt = sha256h_pkg::ST_ROUND;
          cnt_nxt   = 6'd0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      sha256h_pkg::ST_ROUND: begin
        v_nxt[0] = t1 + t2;
        v_nxt[1] = v_r[0];
        v_nxt[2] = v_r[1];
        v_nxt[3] = v_r[2];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[5] = v_r[4];
        v_nxt[6] = v_r[5];
        v_nxt[7] = v_r[6];
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15] = w_new;
        if (cnt_r == sha256h_pkg::ROUND_LAST) begin
          state_nxt = sha256h_pkg::ST_UPDATE;
          cnt_nxt   = 6'd0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      sha256h_pkg::ST_UPDATE: begin
        // Read entry n while writing entry n-1 back; rotate the working variables.
        if (cnt_r != 6'd0) begin
          cv_we                  = 1'b1;
          cv_valid_nxt[cv_waddr] = 1'b1;
          for (int i = 0; i < 7; i++) begin
            v_nxt[i] = v_r[i + 1];
          end
          v_nxt[7] = v_r[0];
        end
        if (cnt_r == sha256h_pkg::UPDATE_LAST) begin
          cnt_nxt = 6'd0;
          case (after_r)
            sha256h_pkg::AFTER_PAD:  state_nxt = sha256h_pkg::ST_PAD;
            sha256h_pkg::AFTER_ZERO: state_nxt = sha256h_pkg::ST_ZERO;
            sha256h_pkg::AFTER_OUT: begin
              state_nxt = sha256h_pkg::ST_OUT_HI;
              dw_nxt    = 2'd0;
            end
            default: state_nxt = sha256h_pkg::ST_IDLE;
          endcase
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      sha256h_pkg::ST_OUT_HI: begin
        cv_raddr  = {dw_r, 1'b0};
        state_nxt = sha256h_pkg::ST_OUT_LO;
      end

      sha256h_pkg::ST_OUT_LO: begin
        cv_raddr  = {dw_r, 1'b1};
        hi_nxt    = cv_rd_eff;
        state_nxt = sha256h_pkg::ST_OUT_LATCH;
      end

      sha256h_pkg::ST_OUT_LATCH: begin
        cv_raddr = {dw_r, 1'b1};
        // Hold until the output register is free or being emptied this cycle.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = {hi_r, cv_rd_eff};
          out_num_nxt   = dw_r;
          out_last_nxt  = (dw_r == sha256h_pkg::DIGEST_LAST);
          if (dw_r == sha256h_pkg::DIGEST_LAST) begin
            // Message done: back to the initial hash for the next one.
            cv_valid_nxt = 8'd0;
            fill_nxt     = 6'd0;
            len_nxt      = 64'd0;
            state_nxt    = sha256h_pkg::ST_IDLE;
          end else begin
            dw_nxt    = dw_r + 2'd1;
            state_nxt = sha256h_pkg::ST_OUT_HI;
          end
        end
      end

      default: state_nxt = sha256h_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256h_pkg::ST_IDLE;
      after_r     <= sha256h_pkg::AFTER_IDLE;
      cnt_r       <= 6'd0;
      wi_r        <= 4'd0;
      dw_r        <= 2'd0;
      fill_r      <= 6'd0;
      len_r       <= 64'd0;
      cv_valid_r  <= 8'd0;
      cv_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      cnt_r       <= cnt_nxt;
      wi_r        <= wi_nxt;
      dw_r        <= dw_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      cv_valid_r  <= cv_valid_nxt;
      cv_hit_r    <= cv_valid_r[cv_raddr];
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    hi_r         <= hi_nxt;
    cv_raddr_q_r <= cv_raddr;
    out_word_r   <= out_word_nxt;
    out_num_r    <= out_num_nxt;
    out_last_r   <= out_last_nxt;
    for (int i = 0; i < 8; i++) begin
      v_r[i] <= v_nxt[i];
    end
    for (int i = 0; i < 16; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

endmodule

### hw/rtl/sha256h_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the SHA-256 byte stream hasher and the bind that attaches them.
module sha256h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_word,
  input logic [1:0]  out_word_number
);

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
                                && $stable(out_word_number))
    else $error("digest word changed while stalled");

  // Finishing a message keeps the input closed on the next cycle.
  a_eom_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> !in_ready)
    else $error("input accepted right after end of message");

  // No new message starts until the last digest word has been latched.
  a_digest_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_number != 2'd3 |-> !in_ready)
    else $error("input open while digest words are pending");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sha256_byte_stream_hasher sha256h_checker u_sha256h_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_end_of_message(in_ch.end_of_message),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_digest_word  (out_ch.digest_word),
  .out_word_number  (out_ch.word_number)
);

### test/sha256_byte_stream_hasher_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the SHA-256 byte stream hasher, random idling on both channels.
module sha256_byte_stream_hasher_test;

  // Cycle budget for the whole run.
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Accepted transactions before the receiver goes quiet for one long stretch.
  localparam int unsigned HOLD_AT     = 120;
  localparam int unsigned HOLD_CYCLES = 3000;
  // Cycles to keep watching the result channel once nothing is outstanding; covers a
  // full compression that a trailing byte may still start.
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned REPORT_MAX    = 10;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned RANDOM_MSGS   = 10;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One input transaction; wait_drain makes the driver hold it back until every
  // digest word already owed has been received, unless the long hold is running.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    logic       wait_drain;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;
  } digest_part_t;

  logic clk;
  logic rst_n;

  sha256h_in_if  in_bus();
  sha256h_out_if out_bus();

  sha256_byte_stream_hasher u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  msg_item_t    byte_queue[$];    // transactions still to be offered, head is on the bus
  digest_part_t digest_queue[$];  // digest words owed by the block, oldest first

  // Running hash of the message in flight, kept alongside the block.
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] bit_count;

  int unsigned items_taken;
  int unsigned planned_items;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  int unsigned send_gap;
  int unsigned send_calm;
  bit          offer;

  int unsigned recv_gap;
  int unsigned recv_calm;
  int unsigned hold_left;
  bit          long_hold_done;
  bit          take;
  digest_part_t got_word;
  digest_part_t want_word;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Hash predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 8; i++) hash_state[i] = SHA_H0[i];
    block_fill = 0;
    bit_count  = '0;
  endfunction

  // Run the 64 rounds over msg_block and fold the result into hash_state.
  function automatic void fold_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    for (i = 0; i < 8; i++) v[i] = hash_state[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  // Absorb one accepted transaction; on end of message pad, fold and queue the
  // four digest words, then start over from the initial hash.
  function automatic void hash_item(input msg_item_t it);
    digest_part_t part;
    int i;
    if (it.byte_present) begin
      msg_block[block_fill] = it.data_byte;
      block_fill++;
      bit_count = bit_count + 64'd8;
      if (block_fill == 64) begin
        fold_block();
        block_fill = 0;
      end
    end
    if (!it.end_of_message) return;
    msg_block[block_fill] = sha256h_pkg::PAD_BYTE;
    block_fill++;
    // No room left for the length field: close this block and pad a fresh one.
    if (block_fill > 56) begin
      while (block_fill < 64) begin
        msg_block[block_fill] = 8'h00;
        block_fill++;
      end
      fold_block();
      block_fill = 0;
    end
    while (block_fill < 56) begin
      msg_block[block_fill] = 8'h00;
      block_fill++;
    end
    for (i = 0; i < 8; i++) msg_block[63-i] = bit_count[8*i +: 8];
    fold_block();
    for (i = 0; i < 4; i++) begin
      part.digest_word = {hash_state[2*i], hash_state[2*i+1]};
      part.word_number = 2'(i);
      part.last_word   = (i == 3);
      digest_queue.push_back(part);
    end
    restart_hash();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_item(input logic [7:0] data, input bit present, input bit eom,
                            input bit drain);
    msg_item_t it;
    it.data_byte      = data;
    it.byte_present   = present;
    it.end_of_message = eom;
    it.wait_drain     = drain;
    byte_queue.push_back(it);
    if (present || eom) planned_items++;
  endtask

  // Queue a message of len random bytes; the last byte rides on the end transaction
  // half of the time, otherwise the end transaction is empty. Sprinkle ignored
  // transactions (no byte, no end) in between.
  task automatic queue_message(input int unsigned len, input bit drain);
    int unsigned k;
    bit carry;
    carry = (len != 0) && ($urandom_range(0, 1) == 1);
    for (k = 0; k < len - carry; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(8'($urandom), 1'b0, 1'b0, drain);
        drain = 1'b0;
      end
      queue_item(8'($urandom), 1'b1, 1'b0, drain);
      drain = 1'b0;
    end
    queue_item(8'($urandom), carry, 1'b1, drain);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the head of byte_queue, hold it until accepted, then pause
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        hash_item(byte_queue.pop_front());
        items_taken++;
        offer = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = pick_pause();
          if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(30, 80);
        end
      end else begin
        // Keep a transaction on the bus until it goes through.
        offer = in_bus.valid;
      end
      // Keep pushing while the receiver is held off, so the block backs up.
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].wait_drain && digest_queue.size() != 0 &&
                       hold_left == 0)) begin
          offer = 1'b1;
        end
      end
      in_bus.valid <= offer;
      if (offer) begin
        in_bus.data_byte      <= byte_queue[0].data_byte;
        in_bus.byte_present   <= byte_queue[0].byte_present;
        in_bus.end_of_message <= byte_queue[0].end_of_message;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold: start once enough transactions went in, count it down
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && items_taken >= HOLD_AT) begin
        long_hold_done <= 1'b1;
        hold_left      <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each digest word against the oldest one owed, drive ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_word.digest_word = out_bus.digest_word;
        got_word.word_number = out_bus.word_number;
        got_word.last_word   = out_bus.last_word;
        if (digest_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] unexpected digest word %h word_number %0d last_word %0d", $realtime,
                     got_word.digest_word, got_word.word_number, got_word.last_word);
          end
        end else begin
          want_word = digest_queue.pop_front();
          if (got_word !== want_word) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("[%0t] digest mismatch: expected %h/%0d/%0d, got %h/%0d/%0d", $realtime,
                       want_word.digest_word, want_word.word_number, want_word.last_word,
                       got_word.digest_word, got_word.word_number, got_word.last_word);
            end
          end
        end
      end
      // Stay quiet for the whole long hold.
      take = 1'b0;
      if (hold_left > 0) begin
        take = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end else begin
        take = 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else if ($urandom_range(0, 99) < 20) begin
          recv_gap = pick_pause();
          if ($urandom_range(0, 99) < 5) recv_calm = $urandom_range(100, 300);
        end
      end
      out_bus.ready <= take;
    end
  end

  // Watchdog: fail the run if it is still going at the cycle budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned msgs;
    int unsigned r;
    int unsigned len;
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.data_byte      = 8'h00;
    in_bus.byte_present   = 1'b0;
    in_bus.end_of_message = 1'b0;
    out_bus.ready         = 1'b0;
    items_taken    = 0;
    planned_items  = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_gap       = 0;
    send_calm      = 0;
    recv_gap       = 0;
    recv_calm      = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    restart_hash();

    // Empty message: an end transaction with no byte gives the hash of nothing.
    queue_item(8'h00, 1'b0, 1'b1, 1'b0);
    // "abc", last byte carried by the end transaction.
    queue_item(8'h61, 1'b1, 1'b0, 1'b0);
    queue_item(8'h62, 1'b1, 1'b0, 1'b0);
    queue_item(8'h63, 1'b1, 1'b1, 1'b0);
    // Single all-ones byte on the end transaction.
    queue_item(8'hff, 1'b1, 1'b1, 1'b0);
    // Single zero byte, then an empty end.
    queue_item(8'h00, 1'b1, 1'b0, 1'b0);
    queue_item(8'hff, 1'b0, 1'b1, 1'b0);
    // Ignored transaction, then an empty end whose byte must not count.
    queue_item(8'hff, 1'b0, 1'b0, 1'b0);
    queue_item(8'haa, 1'b0, 1'b1, 1'b0);

    // Random messages: many short, many around the pad and block boundaries,
    // a few longer ones up to 130 bytes. The first one waits for the directed
    // digests to drain, others now and then.
    planned_items = 0;
    msgs = 0;
    while (planned_items < RANDOM_ITEMS || msgs < RANDOM_MSGS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        len = $urandom_range(0, 12);
      end else if (r < 80) begin
        case ($urandom_range(0, 5))
          0:       len = 55;
          1:       len = 56;
          2:       len = 57;
          3:       len = 63;
          4:       len = 64;
          default: len = 65;
        endcase
      end else begin
        len = $urandom_range(13, 130);
      end
      queue_message(len, (msgs == 0) || ($urandom_range(0, 99) < 15));
      msgs++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0) @(posedge clk);
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/sha256h_pkg.sv
hw/rtl/sha256h_if.sv
hw/rtl/sha256h_ram.sv
hw/rtl/sha256_byte_stream_hasher.sv
hw/rtl/sha256h_checker.sv
test/sha256_byte_stream_hasher_test.sv
